@@ design/tte_pkg.sv @@
package tte_pkg;

    // Table geometry. The slot is the low bits of the key, so the entry
    // count is a power of two.
    localparam int TABLE_ENTRIES = 4096;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    // Field widths.
    localparam int KEY_W   = 64;
    localparam int SCORE_W = 32;
    localparam int DEPTH_W = 8;
    localparam int BOUND_W = 2;

    // Request kinds.
    typedef enum logic {
        CMD_STORE  = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_cmd;

    // Bound kinds held with an entry.
    localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
    localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
    localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd2;

    // One table entry as it sits in memory.
    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0]        depth;
        logic [BOUND_W-1:0]        bound;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // A classified request passed from the front end to the table.
    typedef struct packed {
        t_cmd                      cmd;
        logic [IDX_W-1:0]          idx;
        t_entry                    entry;
        logic signed [SCORE_W-1:0] alpha;
        logic signed [SCORE_W-1:0] beta;
    } t_req;

    // Status the table side reports back to the front end.
    typedef struct packed {
        logic clearing;
        logic ready;
    } t_back_status;

endpackage

@@ design/tte_front.sv @@
module tte_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    output logic                               o_full,
    input  logic                               i_command,
    input  logic [tte_pkg::KEY_W-1:0]          i_position_key,
    input  logic signed [tte_pkg::SCORE_W-1:0] i_entry_score,
    input  logic [tte_pkg::DEPTH_W-1:0]        i_search_depth,
    input  logic [tte_pkg::BOUND_W-1:0]        i_bound_kind,
    input  logic signed [tte_pkg::SCORE_W-1:0] i_alpha_in,
    input  logic signed [tte_pkg::SCORE_W-1:0] i_beta_in,
    output logic                               o_req_valid,
    output tte_pkg::t_req                      o_req,
    input  tte_pkg::t_back_status              i_status
);
    import tte_pkg::*;

    t_req       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    t_req       new_req;
    logic       push_ok;
    logic       pop_ok;

    // Classify the incoming word: request kind and table slot.
    always_comb begin
        new_req.cmd         = t_cmd'(i_command);
        new_req.idx         = i_position_key[IDX_W-1:0];
        new_req.entry.key   = i_position_key;
        new_req.entry.score = i_entry_score;
        new_req.entry.depth = i_search_depth;
        new_req.entry.bound = i_bound_kind;
        new_req.alpha       = i_alpha_in;
        new_req.beta        = i_beta_in;
    end

    // The queue refuses words while it is full or the table is being cleared.
    assign o_full      = (r_count == 2'd2) || i_status.clearing;
    assign push_ok     = i_push && !o_full;
    assign o_req_valid = (r_count != 2'd0);
    assign pop_ok      = o_req_valid && i_status.ready;
    assign o_req       = r_q[r_rd_ptr];

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push_ok} - {1'b0, pop_ok};
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr_ptr] <= new_req;
        end
    end

endmodule

@@ design/tte_back.sv @@
module tte_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_req_valid,
    input  tte_pkg::t_req                      i_req,
    output tte_pkg::t_back_status              o_status,
    input  logic                               i_pop,
    output logic                               o_empty,
    output logic                               o_hit,
    output logic signed [tte_pkg::SCORE_W-1:0] o_hit_score,
    output logic signed [tte_pkg::SCORE_W-1:0] o_alpha_out,
    output logic signed [tte_pkg::SCORE_W-1:0] o_beta_out
);
    import tte_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];

    t_state                    r_state;
    logic [IDX_W-1:0]          r_clr_addr;
    t_req                      r_req;
    t_entry                    r_rd;
    logic                      r_out_valid;
    logic                      r_hit;
    logic signed [SCORE_W-1:0] r_hit_score;
    logic signed [SCORE_W-1:0] r_alpha;
    logic signed [SCORE_W-1:0] r_beta;

    logic                      take;
    logic                      out_free;
    logic                      exec_go;
    logic                      lookup_match;
    logic                      store_ok;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic [ENTRY_W-1:0]        wr_data;
    logic                      n_hit;
    logic signed [SCORE_W-1:0] n_hit_score;
    logic signed [SCORE_W-1:0] n_alpha;
    logic signed [SCORE_W-1:0] n_beta;

    // Handshake with the front queue and the result register.
    assign o_status.clearing = (r_state == S_CLEAR);
    assign o_status.ready    = (r_state == S_IDLE);
    assign take              = (r_state == S_IDLE) && i_req_valid;
    assign out_free          = !r_out_valid || i_pop;
    assign exec_go           = (r_state == S_EXEC) && out_free;

    // Match and replacement tests against the slot that was read.
    assign lookup_match = (r_rd.key == r_req.entry.key) && (r_rd.depth >= r_req.entry.depth);
    assign store_ok     = (r_rd.key == '0) || (r_req.entry.depth >= r_rd.depth);

    // Lookup result: an exact entry hits, bounds narrow the window first.
    always_comb begin
        n_hit       = 1'b0;
        n_hit_score = '0;
        n_alpha     = r_req.alpha;
        n_beta      = r_req.beta;
        if (r_req.cmd == CMD_LOOKUP && lookup_match) begin
            if (r_rd.bound == BOUND_EXACT) begin
                n_hit       = 1'b1;
                n_hit_score = r_rd.score;
            end else begin
                if (r_rd.bound == BOUND_LOWER && r_rd.score > r_req.alpha) begin
                    n_alpha = r_rd.score;
                end
                if (r_rd.bound == BOUND_UPPER && r_rd.score < r_req.beta) begin
                    n_beta = r_rd.score;
                end
                if (n_alpha >= n_beta) begin
                    n_hit       = 1'b1;
                    n_hit_score = r_rd.score;
                end
            end
        end
    end

    // Single write port, shared by the clearing sweep and accepted stores.
    always_comb begin
        if (r_state == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = exec_go && (r_req.cmd == CMD_STORE) && store_ok;
            wr_addr = r_req.idx;
            wr_data = r_req.entry;
        end
    end

    // Table memory with a registered read, taken when a request is accepted.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (take) begin
            r_rd <= t_entry'(mem[i_req.idx]);
        end
    end

    // Hold the request while it is carried out.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req <= i_req;
        end
    end

    // Sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (take) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (exec_go) begin
                r_out_valid <= 1'b1;
                r_hit       <= n_hit;
                r_hit_score <= n_hit_score;
                r_alpha     <= n_alpha;
                r_beta      <= n_beta;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_hit       = r_hit;
    assign o_hit_score = r_hit_score;
    assign o_alpha_out = r_alpha;
    assign o_beta_out  = r_beta;

    // A request is carried out only right after it was taken from the queue.
    a_exec_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && $past(r_state) != S_EXEC) |-> $past(r_state) == S_IDLE)
        else $error("request executed without being taken");

    // The clearing sweep covers every slot before requests are served.
    a_clear_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && $past(r_state) == S_CLEAR) |-> $past(r_clr_addr) == LAST_IDX)
        else $error("clearing sweep ended early");

    // A waiting result is not overwritten before it is popped.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_pop) |=>
            (r_out_valid && $stable(r_hit) && $stable(r_hit_score)
             && $stable(r_alpha) && $stable(r_beta)))
        else $error("waiting result overwritten");

    // Without a hit the reported score is zero.
    a_miss_score_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_hit) |-> r_hit_score == '0)
        else $error("nonzero score on a miss");

endmodule

@@ design/transposition_table_engine.sv @@
// Transposition table with depth-preferred replacement, 4096 direct-mapped
// slots indexed by the low bits of the position key.
//
// Input channel: a request word is taken on a rising edge with push high and
// full low. Command 0 stores an entry, command 1 looks a position up.
// Result channel: while empty is low the oldest result is on the o_ ports;
// it is consumed on a rising edge with pop high. Every request gives one
// result word, in request order.
//
// A two-entry queue sits in front of the table sequencer. The sequencer
// reads the slot in S_IDLE and evaluates and writes it back in S_EXEC, which
// waits while the result register is full; it takes no new request until
// that read-modify-write of the single-port table memory is done. A word
// pushed into an empty block passes the queue, r_rd and the result register.
//
// After reset the table is swept to zero, one slot per cycle, over all 4096
// slots; full stays high during the sweep. When the receiver holds pop low,
// one result waits in the output register, the sequencer stalls on the next
// request, and up to two further words queue before full rises.
module transposition_table_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic                               i_command,
    input  logic [tte_pkg::KEY_W-1:0]          i_position_key,
    input  logic signed [tte_pkg::SCORE_W-1:0] i_entry_score,
    input  logic [tte_pkg::DEPTH_W-1:0]        i_search_depth,
    input  logic [tte_pkg::BOUND_W-1:0]        i_bound_kind,
    input  logic signed [tte_pkg::SCORE_W-1:0] i_alpha_in,
    input  logic signed [tte_pkg::SCORE_W-1:0] i_beta_in,
    output logic                               empty,
    input  logic                               pop,
    output logic                               o_hit,
    output logic signed [tte_pkg::SCORE_W-1:0] o_hit_score,
    output logic signed [tte_pkg::SCORE_W-1:0] o_alpha_out,
    output logic signed [tte_pkg::SCORE_W-1:0] o_beta_out
);
    import tte_pkg::*;

    logic         req_valid;
    t_req         req;
    t_back_status status;

    // Front end: accepts and classifies request words.
    tte_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_command      (i_command),
        .i_position_key (i_position_key),
        .i_entry_score  (i_entry_score),
        .i_search_depth (i_search_depth),
        .i_bound_kind   (i_bound_kind),
        .i_alpha_in     (i_alpha_in),
        .i_beta_in      (i_beta_in),
        .o_req_valid    (req_valid),
        .o_req          (req),
        .i_status       (status)
    );

    // Back end: table memory, sequencer and result register.
    tte_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_status    (status),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_hit       (o_hit),
        .o_hit_score (o_hit_score),
        .o_alpha_out (o_alpha_out),
        .o_beta_out  (o_beta_out)
    );

endmodule

@@ tb/sv/transposition_table_engine_tb.sv @@
module transposition_table_engine_tb;
    import tte_pkg::*;

    localparam int RANDOM_WORDS = 1200;
    localparam int CALM_WORDS   = 150;
    localparam int POOL_SLOTS   = 24;
    localparam int POOL_KEYS    = 2 * POOL_SLOTS;
    localparam int LONG_HOLD    = 200;
    // The package names three bound kinds; the fourth code is still storable.
    localparam logic [BOUND_W-1:0] BOUND_SPARE = 2'd3;

    // One result word as the table should answer it.
    typedef struct {
        logic                      hit;
        logic signed [SCORE_W-1:0] score;
        logic signed [SCORE_W-1:0] alpha;
        logic signed [SCORE_W-1:0] beta;
    } t_answer;

    // Shadow copy of the table that predicts every answer in request order.
    class t_shadow_table;
        logic [KEY_W-1:0]          slot_key   [TABLE_ENTRIES];
        logic signed [SCORE_W-1:0] slot_score [TABLE_ENTRIES];
        logic [DEPTH_W-1:0]        slot_depth [TABLE_ENTRIES];
        logic [BOUND_W-1:0]        slot_bound [TABLE_ENTRIES];
        t_answer                   pending_answers[$];
        int errors, stores, writes, lookups, hits;

        function new();
            foreach (slot_key[i]) begin
                slot_key[i]   = '0;
                slot_score[i] = '0;
                slot_depth[i] = '0;
                slot_bound[i] = '0;
            end
            errors  = 0;
            stores  = 0;
            writes  = 0;
            lookups = 0;
            hits    = 0;
        endfunction

        function int pending();
            return pending_answers.size();
        endfunction

        // Apply one accepted request to the shadow table and queue its answer.
        function void note_request(t_cmd cmd, logic [KEY_W-1:0] key,
                                   logic signed [SCORE_W-1:0] score,
                                   logic [DEPTH_W-1:0] depth, logic [BOUND_W-1:0] bound,
                                   logic signed [SCORE_W-1:0] alpha,
                                   logic signed [SCORE_W-1:0] beta);
            logic [IDX_W-1:0]          idx;
            logic signed [SCORE_W-1:0] kept;
            t_answer                   ans;
            idx       = IDX_W'(key % TABLE_ENTRIES);
            ans.hit   = 1'b0;
            ans.score = '0;
            ans.alpha = alpha;
            ans.beta  = beta;
            if (cmd == CMD_STORE) begin
                stores++;
                // A slot holding key zero is free; otherwise an equal or deeper search wins.
                if (slot_key[idx] == '0 || depth >= slot_depth[idx]) begin
                    writes++;
                    slot_key[idx]   = key;
                    slot_score[idx] = score;
                    slot_depth[idx] = depth;
                    slot_bound[idx] = bound;
                end
            end else begin
                lookups++;
                if (slot_key[idx] == key && slot_depth[idx] >= depth) begin
                    kept = slot_score[idx];
                    if (slot_bound[idx] == BOUND_EXACT) begin
                        ans.hit = 1'b1;
                    end else begin
                        // Bounds narrow the window; a closed window is a cutoff.
                        if (slot_bound[idx] == BOUND_LOWER && kept > ans.alpha)
                            ans.alpha = kept;
                        if (slot_bound[idx] == BOUND_UPPER && kept < ans.beta)
                            ans.beta = kept;
                        ans.hit = (ans.alpha >= ans.beta);
                    end
                    if (ans.hit) begin
                        ans.score = kept;
                        hits++;
                    end
                end
            end
            pending_answers.push_back(ans);
        endfunction

        // Compare one popped result word with the oldest predicted answer.
        function void check_answer(logic hit, logic signed [SCORE_W-1:0] score,
                                   logic signed [SCORE_W-1:0] alpha,
                                   logic signed [SCORE_W-1:0] beta);
            t_answer want;
            if (pending_answers.size() == 0) begin
                $error("result word popped with no request outstanding");
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            if (hit !== want.hit) begin
                $error("o_hit: expected %0d, got %0d", want.hit, hit);
                errors++;
            end
            if (score !== want.score) begin
                $error("o_hit_score: expected %0d, got %0d", want.score, score);
                errors++;
            end
            if (alpha !== want.alpha) begin
                $error("o_alpha_out: expected %0d, got %0d", want.alpha, alpha);
                errors++;
            end
            if (beta !== want.beta) begin
                $error("o_beta_out: expected %0d, got %0d", want.beta, beta);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      push           = 1'b0;
    logic                      pop            = 1'b0;
    logic                      i_command      = 1'b0;
    logic [KEY_W-1:0]          i_position_key = '0;
    logic signed [SCORE_W-1:0] i_entry_score  = '0;
    logic [DEPTH_W-1:0]        i_search_depth = '0;
    logic [BOUND_W-1:0]        i_bound_kind   = '0;
    logic signed [SCORE_W-1:0] i_alpha_in     = '0;
    logic signed [SCORE_W-1:0] i_beta_in      = '0;
    logic                      full;
    logic                      empty;
    logic                      o_hit;
    logic signed [SCORE_W-1:0] o_hit_score;
    logic signed [SCORE_W-1:0] o_alpha_out;
    logic signed [SCORE_W-1:0] o_beta_out;

    t_shadow_table    shadow = new();
    logic [KEY_W-1:0] key_pool[POOL_KEYS];
    bit               calm          = 1'b0;
    int               send_idle_pct = 0;
    int               results_seen  = 0;

    transposition_table_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_command      (i_command),
        .i_position_key (i_position_key),
        .i_entry_score  (i_entry_score),
        .i_search_depth (i_search_depth),
        .i_bound_kind   (i_bound_kind),
        .i_alpha_in     (i_alpha_in),
        .i_beta_in      (i_beta_in),
        .empty          (empty),
        .pop            (pop),
        .o_hit          (o_hit),
        .o_hit_score    (o_hit_score),
        .o_alpha_out    (o_alpha_out),
        .o_beta_out     (o_beta_out)
    );

    always #10 i_clk = ~i_clk;

    // Offer one request word, wait until it is taken, then maybe idle a while.
    task automatic send_request(t_cmd cmd, logic [KEY_W-1:0] key,
                                logic signed [SCORE_W-1:0] score,
                                logic [DEPTH_W-1:0] depth, logic [BOUND_W-1:0] bound,
                                logic signed [SCORE_W-1:0] alpha,
                                logic signed [SCORE_W-1:0] beta);
        i_command      <= cmd;
        i_position_key <= key;
        i_entry_score  <= score;
        i_search_depth <= depth;
        i_bound_kind   <= bound;
        i_alpha_in     <= alpha;
        i_beta_in      <= beta;
        push           <= 1'b1;
        do @(posedge i_clk); while (full !== 1'b0);
        shadow.note_request(cmd, key, score, depth, bound, alpha, beta);
        if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task automatic store_entry(logic [KEY_W-1:0] key, logic signed [SCORE_W-1:0] score,
                               logic [DEPTH_W-1:0] depth, logic [BOUND_W-1:0] bound);
        send_request(CMD_STORE, key, score, depth, bound, $urandom(), $urandom());
    endtask

    task automatic probe(logic [KEY_W-1:0] key, logic [DEPTH_W-1:0] depth,
                         logic signed [SCORE_W-1:0] alpha, logic signed [SCORE_W-1:0] beta);
        send_request(CMD_LOOKUP, key, $urandom(), depth, BOUND_W'($urandom()), alpha, beta);
    endtask

    // Scores cluster near zero so bounds and windows interact, with some full-range values.
    function automatic logic signed [SCORE_W-1:0] pick_score();
        if ($urandom_range(0, 9) < 6)
            return $urandom_range(0, 40) - 20;
        return $urandom();
    endfunction

    // Most keys come from a small pool that collides on a few slots.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return key_pool[$urandom_range(0, POOL_KEYS - 1)];
        if (r < 95)
            return {$urandom(), $urandom()};
        return '0;
    endfunction

    function automatic logic [DEPTH_W-1:0] pick_depth();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return '1;
        if (r < 5)
            return $urandom_range(0, 255);
        return $urandom_range(0, 12);
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    // Request side: reset, directed words, then random traffic.
    initial begin
        logic [IDX_W-1:0] slot;
        logic [KEY_W-1:0] k1, k2, k3, k4;
        t_cmd             cmd;
        k1 = 64'hA5A5_0000_0000_0005;
        k2 = 64'h5A5A_1234_0000_0005;
        k3 = 64'h0123_4567_89AB_C007;
        k4 = 64'hFFFF_0000_0000_0009;
        for (int s = 0; s < POOL_SLOTS; s++) begin
            slot = (s == 0) ? '0 : (s == 1) ? '1 : IDX_W'($urandom());
            for (int j = 0; j < 2; j++)
                key_pool[2 * s + j] = {$urandom(), (KEY_W - 32 - IDX_W)'($urandom()), slot};
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Key zero against the cleared table, then the depth gate.
        probe(64'd0, 8'd0, 32'sd10, 32'sd20);
        probe(64'd0, 8'd1, 32'sd10, 32'sd20);
        store_entry(k1, 32'sh7FFF_FFFF, 8'd10, BOUND_EXACT);
        probe(k1, 8'd10, -32'sd1, 32'sd1);
        probe(k1, 8'd11, -32'sd1, 32'sd1);
        // A shallower store to the same slot is refused; an equal depth replaces.
        store_entry(k2, -32'sd1, 8'd9, BOUND_EXACT);
        probe(k2, 8'd0, 32'sd0, 32'sd0);
        store_entry(k2, -32'sd5, 8'd10, BOUND_LOWER);
        probe(k2, 8'd3, -32'sd10, 32'sd100);
        probe(k2, 8'd3, -32'sd10, -32'sd5);
        // Upper bound at the score extremes.
        store_entry(k3, 32'sh8000_0000, 8'd255, BOUND_UPPER);
        probe(k3, 8'd255, 32'sh8000_0000, 32'sh7FFF_FFFF);
        probe(k3, 8'd0, 32'sh7FFF_FFFF, 32'sh8000_0000);
        // The spare bound code leaves the window alone.
        store_entry(k4, 32'sd3, 8'd0, BOUND_SPARE);
        probe(k4, 8'd0, 32'sd3, 32'sd3);
        probe(k4, 8'd0, 32'sd2, 32'sd3);
        // A slot keyed zero still counts as free after a deep store.
        store_entry(64'd0, 32'sd77, 8'd200, BOUND_LOWER);
        probe(64'd0, 8'd200, 32'sd100, 32'sd50);
        store_entry(64'h1000, 32'sd9, 8'd0, BOUND_EXACT);
        probe(64'd0, 8'd0, 32'sd0, 32'sd0);
        // All-ones key lands in the last slot.
        store_entry('1, 32'sh8000_0000, 8'd255, BOUND_UPPER);
        probe('1, 8'd255, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        probe(64'h7FFF_FFFF_FFFF_FFFF, 8'd0, 32'sd0, 32'sd1);

        // Random traffic over the colliding key pool; the tail runs without idling.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 50 == 0)
                send_idle_pct = pick_idle_pct();
            calm = (n >= RANDOM_WORDS - CALM_WORDS);
            cmd  = $urandom_range(0, 1) ? CMD_LOOKUP : CMD_STORE;
            send_request(cmd, pick_key(), pick_score(), pick_depth(),
                         BOUND_W'($urandom_range(0, 3)), pick_score(), pick_score());
        end
        push <= 1'b0;

        for (int k = 0; k < 4000 && shadow.pending() != 0; k++)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (shadow.pending() != 0) begin
            $error("%0d result words never arrived", shadow.pending());
            shadow.errors++;
        end
        $display("Checked %0d result words: %0d stores (%0d written), %0d lookups (%0d hits).",
                 results_seen, shadow.stores, shadow.writes, shadow.lookups, shadow.hits);
        $display("Covered key zero, score extremes, all bound codes, slot collisions, a full stall.");
        if (shadow.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Result side: pop with random stalls and one long hold-off that fills the block.
    initial begin
        int hold_left;
        int pop_idle_pct;
        bit long_hold_done;
        hold_left      = 0;
        pop_idle_pct   = 0;
        long_hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop === 1'b1 && empty === 1'b0) begin
                shadow.check_answer(o_hit, o_hit_score, o_alpha_out, o_beta_out);
                results_seen++;
                if (results_seen % 50 == 0)
                    pop_idle_pct = pick_idle_pct();
            end
            if (!long_hold_done && results_seen == 300) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
            end else if (hold_left == 0 && !calm && $urandom_range(0, 99) < pop_idle_pct) begin
                hold_left = $urandom_range(1, 9);
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Watchdog: covers the clearing sweep plus the slowest legal run many times over.
    initial begin
        #6_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
design/tte_pkg.sv
design/tte_front.sv
design/tte_back.sv
design/transposition_table_engine.sv
tb/sv/transposition_table_engine_tb.sv
